// ===== rtl/psf_pkg.sv =====
// Package for the planar span fill block: shared constants and the
// controller/datapath command and status structures. No dependencies.
package psf_pkg;

  // Default ceiling on bytes per scan line used in address arithmetic
  localparam int MAX_ROW_BYTES_DEF = 64;

  // Field widths
  localparam int X_W      = 9;
  localparam int ROW_W    = 9;
  localparam int COLOUR_W = 4;
  localparam int ADDR_W   = 16;
  localparam int MASK_W   = 8;
  localparam int RB_W     = 7;
  localparam int BYTE_W   = X_W - 3;

  // Result kinds
  localparam logic KIND_MEM = 1'b0;
  localparam logic KIND_REG = 1'b1;

  // Request kinds
  localparam logic ACT_SPAN = 1'b0;
  localparam logic ACT_FLIP = 1'b1;

  // Display controller start address registers
  localparam logic [ADDR_W-1:0] REG_START_HIGH = 16'h000C;
  localparam logic [ADDR_W-1:0] REG_START_LOW  = 16'h000D;

  localparam logic [MASK_W-1:0] FULL_MASK = 8'hFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_BUFFER  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_ZERO_BASE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_ONE_BASE  = 8'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture an accepted request
    logic calc;   // form the scan line address
    logic emit;   // load the output register with the next result
  } psf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_flip;   // request on the input is a flip
    logic flip_en;   // double buffering is on
    logic out_free;  // output register can take a result this cycle
    logic final_res; // result being formed is the last of its request
  } psf_stat_t;

endpackage

// ===== rtl/planar_span_fill_with_page_flip_top.sv =====
// Planar span fill with page flip, top level. Depends on psf_pkg, psf_ctrl, psf_dp.
// Flow: an accepted request is captured, its scan line address is registered, and
// its results then pass through the output register in turn, one per cycle while
// the receiver keeps up; one request at a time, set by the output register and the
// address step before it. A flip with one page in use gives no result.
// Reset (rst, synchronous): registers return to their defaults, page zero shown.
module planar_span_fill_with_page_flip_top import psf_pkg::*; #(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // Requests
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // x_first, x_second, row, colour, pad
  input  logic                 s_axis_tuser,  // action
  // Results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // target, payload, pen, pad
  output logic                 m_axis_tuser,  // kind
  output logic                 m_axis_tlast
);

  psf_cmd_t  cmd;
  psf_stat_t stat;

  psf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  psf_dp #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

// ===== rtl/psf_ctrl.sv =====
// Controller for the planar span fill block: sequences capture, address
// calculation and result emission. Depends on psf_pkg.
module psf_ctrl import psf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  psf_stat_t stat,
  output psf_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state, state_next;
  logic       accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Decode commands and the next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          // drop a flip when only one page is in use
          if (!(stat.in_flip && !stat.flip_en)) state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.final_res) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== rtl/psf_dp.sv =====
// Datapath for the planar span fill block: configuration registers, shown
// page, request capture, line address, byte counter and output register.
// Depends on psf_pkg.
module psf_dp import psf_pkg::*; #(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [31:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast,
  input  psf_cmd_t             cmd,
  output psf_stat_t            stat
);

  localparam logic [RB_W-1:0] RB_MAX = RB_W'(MAX_ROW_BYTES);

  // Configuration and page state
  logic [RB_W-1:0]   row_bytes;
  logic              double_buffer;
  logic [ADDR_W-1:0] page_zero_base;
  logic [ADDR_W-1:0] page_one_base;
  logic              shown_page;

  // Captured request
  logic                action;
  logic [X_W-1:0]      xa, xb;
  logic [ROW_W-1:0]    row;
  logic [COLOUR_W-1:0] pen;
  logic [ADDR_W-1:0]   line;
  logic [BYTE_W-1:0]   cnt;

  // Output register
  logic                out_valid;
  logic                out_kind;
  logic                out_last;
  logic [ADDR_W-1:0]   out_target;
  logic [MASK_W-1:0]   out_payload;
  logic [COLOUR_W-1:0] out_pen;

  logic [X_W-1:0]      in_x1, in_x2;
  logic [ROW_W-1:0]    in_row;
  logic [COLOUR_W-1:0] in_colour;
  logic [RB_W-1:0]     rb_sat;
  logic [ADDR_W-1:0]   draw_base, flip_base, product;
  logic [BYTE_W-1:0]   bl, br;
  logic [MASK_W-1:0]   lmask, rmask, span_mask;
  logic                final_res;
  logic [ADDR_W-1:0]   res_target;
  logic [MASK_W-1:0]   res_payload;
  logic [COLOUR_W-1:0] res_pen;

  assign in_x1     = s_axis_tdata[8:0];
  assign in_x2     = s_axis_tdata[17:9];
  assign in_row    = s_axis_tdata[26:18];
  assign in_colour = s_axis_tdata[30:27];

  assign cfg_ready = 1'b1;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes      <= 7'd40;
      double_buffer  <= 1'b1;
      page_zero_base <= 16'd0;
      page_one_base  <= 16'd8000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROW_BYTES:      row_bytes      <= cfg_data[RB_W-1:0];
        CFG_DOUBLE_BUFFER:  double_buffer  <= cfg_data[0];
        CFG_PAGE_ZERO_BASE: page_zero_base <= cfg_data;
        CFG_PAGE_ONE_BASE:  page_one_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address arithmetic
  assign rb_sat    = (row_bytes > RB_MAX) ? RB_MAX : row_bytes;
  assign draw_base = (double_buffer && !shown_page) ? page_one_base : page_zero_base;
  assign flip_base = shown_page ? page_zero_base : page_one_base;
  assign product   = {{(ADDR_W-ROW_W){1'b0}}, row} * {{(ADDR_W-RB_W){1'b0}}, rb_sat};

  assign bl        = xa[X_W-1:3];
  assign br        = xb[X_W-1:3];
  assign lmask     = FULL_MASK >> xa[2:0];
  assign rmask     = FULL_MASK << (3'd7 - xb[2:0]);

  // Pick the mask for the current byte
  always_comb begin
    if (bl == br)       span_mask = lmask & rmask;
    else if (cnt == bl) span_mask = lmask;
    else if (cnt == br) span_mask = rmask;
    else                span_mask = FULL_MASK;
  end

  // Form the next result
  always_comb begin
    if (action == ACT_FLIP) begin
      final_res   = cnt[0];
      res_target  = cnt[0] ? REG_START_HIGH : REG_START_LOW;
      res_payload = cnt[0] ? flip_base[15:8] : flip_base[7:0];
      res_pen     = '0;
    end else begin
      final_res   = (cnt == br);
      res_target  = line + {{(ADDR_W-BYTE_W){1'b0}}, cnt};
      res_payload = span_mask;
      res_pen     = pen;
    end
  end

  // Capture the request with its ends in order
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= s_axis_tuser;
      row    <= in_row;
      pen    <= in_colour;
      if (in_x2 < in_x1) begin
        xa <= in_x2;
        xb <= in_x1;
      end else begin
        xa <= in_x1;
        xb <= in_x2;
      end
    end
    if (cmd.calc) line <= draw_base + product;
  end

  // Advance the byte counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (s_axis_tuser == ACT_FLIP)      cnt <= '0;
      else if (in_x2 < in_x1)            cnt <= in_x2[X_W-1:3];
      else                               cnt <= in_x1[X_W-1:3];
    end else if (cmd.emit) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Toggle the shown page when a flip hands over its last result
  always_ff @(posedge clk) begin
    if (rst) shown_page <= 1'b0;
    else if (cmd.emit && final_res && action == ACT_FLIP) shown_page <= ~shown_page;
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (m_axis_tready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind    <= (action == ACT_FLIP) ? KIND_REG : KIND_MEM;
      out_last    <= final_res;
      out_target  <= res_target;
      out_payload <= res_payload;
      out_pen     <= res_pen;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'b0, out_pen, out_payload, out_target};

  assign stat.in_flip   = s_axis_tuser;
  assign stat.flip_en   = double_buffer;
  assign stat.out_free  = !out_valid || m_axis_tready;
  assign stat.final_res = final_res;

endmodule

// ===== bench/planar_span_fill_with_page_flip_top_test.sv =====
// Self-checking bench for planar_span_fill_with_page_flip_top: directed and random span and
// flip requests against a behavioural model of the byte writes and start address updates.
// Depends on psf_pkg and the top level with its submodules.
module planar_span_fill_with_page_flip_top_test;
  import psf_pkg::*;

  localparam int ROW_CAP         = MAX_ROW_BYTES_DEF;
  localparam int SETTLE_CYCLES   = 8;
  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 6;
  localparam int PHASE_REQUESTS  = 65;
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_PCT        = 36;
  localparam int PREDICTED       = -1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd200;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   target;
    logic [MASK_W-1:0]   payload;
    logic [COLOUR_W-1:0] pen;
    logic                last;
  } vid_write_t;

  typedef struct packed {
    logic                act;
    logic [X_W-1:0]      x1;
    logic [X_W-1:0]      x2;
    logic [ROW_W-1:0]    rw;
    logic [COLOUR_W-1:0] col;
  } draw_req_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          val;
    draw_req_t            req;
    int                   n_typed;
    vid_write_t           e0;
    vid_write_t           e1;
  } dir_step_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;  // x_first, x_second, row, colour, pad
  logic                 s_axis_tuser = 1'b0; // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;       // target, payload, pen, pad
  logic                 m_axis_tuser;       // kind
  logic                 m_axis_tlast;

  // Model state: registers at their reset values, page zero shown
  logic [RB_W-1:0]   mdl_row_bytes = 7'd40;
  logic              mdl_dbuf = 1'b1;
  logic [ADDR_W-1:0] mdl_base0 = 16'd0;
  logic [ADDR_W-1:0] mdl_base1 = 16'd8000;
  logic              mdl_shown = 1'b0;

  vid_write_t planned_writes[$];
  vid_write_t awaited_writes[$];
  dir_step_t  dir_steps[$];

  int send_idle_pct = IDLE_PCT;
  int take_idle_pct = IDLE_PCT;
  int hold_asks = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int flips_sent = 0;
  int reg_writes = 0;
  bit cfg_open = 1'b0;
  vid_write_t got_wr;
  vid_write_t want_wr;

  planar_span_fill_with_page_flip_top #(.MAX_ROW_BYTES(ROW_CAP)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic vid_write_t mk_wr(input logic k, input logic [ADDR_W-1:0] t,
                                       input logic [MASK_W-1:0] p,
                                       input logic [COLOUR_W-1:0] c, input logic l);
    return '{k, t, p, c, l};
  endfunction

  function automatic draw_req_t mk_req(input logic a, input int x1, input int x2,
                                       input int rw, input int col);
    return '{a, X_W'(x1), X_W'(x2), ROW_W'(rw), COLOUR_W'(col)};
  endfunction

  // Mirror a register write into the model; unknown indexes are dropped
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    case (idx)
      CFG_ROW_BYTES:      mdl_row_bytes = val[RB_W-1:0];
      CFG_DOUBLE_BUFFER:  mdl_dbuf = val[0];
      CFG_PAGE_ZERO_BASE: mdl_base0 = val;
      CFG_PAGE_ONE_BASE:  mdl_base1 = val;
      default: ;
    endcase
  endfunction

  // Work out the byte writes or start address writes that one request causes
  function automatic void plan_request(input draw_req_t r);
    logic [X_W-1:0]    lo, hi;
    logic [RB_W-1:0]   rb;
    logic [ADDR_W-1:0] page, line;
    logic [MASK_W-1:0] lmask, rmask;
    int                bl, br;
    planned_writes.delete();
    if (r.act == ACT_FLIP) begin
      if (mdl_dbuf) begin
        page = mdl_shown ? mdl_base0 : mdl_base1;
        mdl_shown = ~mdl_shown;
        planned_writes.push_back(mk_wr(KIND_REG, REG_START_LOW, page[7:0], '0, 1'b0));
        planned_writes.push_back(mk_wr(KIND_REG, REG_START_HIGH, page[15:8], '0, 1'b1));
      end
    end else begin
      lo = (r.x2 < r.x1) ? r.x2 : r.x1;
      hi = (r.x2 < r.x1) ? r.x1 : r.x2;
      // saturate over-wide rows
      rb = (mdl_row_bytes > ROW_CAP) ? RB_W'(ROW_CAP) : mdl_row_bytes;
      page = (mdl_dbuf && !mdl_shown) ? mdl_base1 : mdl_base0;
      line = page + r.rw * rb;
      lmask = FULL_MASK >> lo[2:0];
      rmask = FULL_MASK << (3'd7 - hi[2:0]);
      bl = lo[X_W-1:3];
      br = hi[X_W-1:3];
      if (bl == br) begin
        planned_writes.push_back(mk_wr(KIND_MEM, line + bl, lmask & rmask, r.col, 1'b1));
      end else begin
        planned_writes.push_back(mk_wr(KIND_MEM, line + bl, lmask, r.col, 1'b0));
        for (int b = bl + 1; b < br; b++)
          planned_writes.push_back(mk_wr(KIND_MEM, line + b, FULL_MASK, r.col, 1'b0));
        planned_writes.push_back(mk_wr(KIND_MEM, line + br, rmask, r.col, 1'b1));
      end
    end
  endfunction

  function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    dir_step_t st;
    st.is_cfg = 1'b1;
    st.idx = idx;
    st.val = val;
    st.req = '0;
    st.n_typed = PREDICTED;
    st.e0 = '0;
    st.e1 = '0;
    dir_steps.push_back(st);
  endfunction

  function automatic void add_req_row(input draw_req_t r, input int n_typed,
                                      input vid_write_t e0, input vid_write_t e1);
    dir_step_t st;
    st.is_cfg = 1'b0;
    st.idx = '0;
    st.val = '0;
    st.req = r;
    st.n_typed = n_typed;
    st.e0 = e0;
    st.e1 = e1;
    dir_steps.push_back(st);
  endfunction

  function automatic logic [15:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic note_mismatch(input string why, input vid_write_t want, input vid_write_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch (%s) at %0t: expected kind %0d target %h payload %h pen %h last %0d,",
               why, $time, want.kind, want.target, want.payload, want.pen, want.last,
               " got kind %0d target %h payload %h pen %h last %0d",
               got.kind, got.target, got.payload, got.pen, got.last);
  endtask

  // Write one register; valid stays high until the next request lowers it
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    reg_writes++;
    cfg_open = 1'b1;
  endtask

  // Offer one request after a random gap; take typed expectations where given
  task automatic send_request(input draw_req_t r, input int n_typed,
                              input vid_write_t e0, input vid_write_t e1);
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, r.col, r.rw, r.x2, r.x1};
    s_axis_tuser <= r.act;
    do @(posedge clk); while (!s_axis_tready);
    plan_request(r);
    if (n_typed == PREDICTED) begin
      foreach (planned_writes[i]) awaited_writes.push_back(planned_writes[i]);
    end else begin
      if (n_typed > 0) awaited_writes.push_back(e0);
      if (n_typed > 1) awaited_writes.push_back(e1);
    end
    requests_sent++;
    if (r.act == ACT_FLIP) flips_sent++;
  endtask

  // Hold the input until every expected write is back and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != holds_done) begin
      holds_done <= hold_asks;
      hold_left <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_wr = mk_wr(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16],
                     m_axis_tdata[27:24], m_axis_tlast);
      results_seen++;
      if (awaited_writes.size() == 0) begin
        note_mismatch("unexpected", '0, got_wr);
      end else begin
        want_wr = awaited_writes.pop_front();
        if (got_wr !== want_wr) note_mismatch("field", want_wr, got_wr);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    dir_step_t   st;
    draw_req_t   r;
    int          w;
    logic [15:0] v;
    bit          prev_req;

    // Directed table, reset values first
    add_req_row(mk_req(ACT_SPAN, 0, 7, 0, 15), 1,
                mk_wr(KIND_MEM, 16'h1F40, 8'hFF, 4'hF, 1'b1), '0);
    add_req_row(mk_req(ACT_SPAN, 7, 0, 0, 0), 1,
                mk_wr(KIND_MEM, 16'h1F40, 8'hFF, 4'h0, 1'b1), '0);
    add_req_row(mk_req(ACT_SPAN, 3, 3, 0, 9), 1,
                mk_wr(KIND_MEM, 16'h1F40, 8'h10, 4'h9, 1'b1), '0);
    add_req_row(mk_req(ACT_SPAN, 511, 504, 0, 6), 1,
                mk_wr(KIND_MEM, 16'h1F7F, 8'hFF, 4'h6, 1'b1), '0);
    add_req_row(mk_req(ACT_SPAN, 0, 511, 511, 15), PREDICTED, '0, '0);
    add_req_row(mk_req(ACT_SPAN, 511, 0, 2, 3), PREDICTED, '0, '0);
    add_req_row(mk_req(ACT_SPAN, 5, 20, 1, 10), PREDICTED, '0, '0);
    add_req_row(mk_req(ACT_SPAN, 9, 14, 100, 1), PREDICTED, '0, '0);
    add_req_row(mk_req(ACT_FLIP, 0, 0, 0, 0), 2,
                mk_wr(KIND_REG, REG_START_LOW, 8'h40, 4'h0, 1'b0),
                mk_wr(KIND_REG, REG_START_HIGH, 8'h1F, 4'h0, 1'b1));
    add_req_row(mk_req(ACT_SPAN, 0, 7, 0, 12), 1,
                mk_wr(KIND_MEM, 16'h0000, 8'hFF, 4'hC, 1'b1), '0);
    // flip fields set high and ignored
    add_req_row(mk_req(ACT_FLIP, 511, 511, 511, 15), 2,
                mk_wr(KIND_REG, REG_START_LOW, 8'h00, 4'h0, 1'b0),
                mk_wr(KIND_REG, REG_START_HIGH, 8'h00, 4'h0, 1'b1));
    // over-wide rows saturate; page one at the top of memory wraps
    add_cfg_row(CFG_ROW_BYTES, 16'hFF7F);
    add_cfg_row(CFG_PAGE_ONE_BASE, 16'hFFFF);
    add_req_row(mk_req(ACT_SPAN, 0, 511, 511, 5), PREDICTED, '0, '0);
    add_req_row(mk_req(ACT_SPAN, 8, 15, 1, 2), PREDICTED, '0, '0);
    // zero row width, single page, unknown register
    add_cfg_row(CFG_ROW_BYTES, 16'h0000);
    add_cfg_row(CFG_DOUBLE_BUFFER, 16'hFFFE);
    add_cfg_row(CFG_PAGE_ZERO_BASE, 16'hFFF8);
    add_cfg_row(CFG_UNUSED, 16'hBEEF);
    add_req_row(mk_req(ACT_SPAN, 0, 511, 300, 7), PREDICTED, '0, '0);
    add_req_row(mk_req(ACT_FLIP, 1, 2, 3, 4), 0, '0, '0);
    add_req_row(mk_req(ACT_SPAN, 100, 3, 511, 14), PREDICTED, '0, '0);
    add_cfg_row(CFG_DOUBLE_BUFFER, 16'h0001);
    add_cfg_row(CFG_ROW_BYTES, 16'd64);
    add_cfg_row(CFG_PAGE_ZERO_BASE, 16'h1234);
    add_cfg_row(CFG_PAGE_ONE_BASE, 16'hABCD);
    add_req_row(mk_req(ACT_FLIP, 0, 0, 0, 0), 2,
                mk_wr(KIND_REG, REG_START_LOW, 8'hCD, 4'h0, 1'b0),
                mk_wr(KIND_REG, REG_START_HIGH, 8'hAB, 4'h0, 1'b1));
    add_req_row(mk_req(ACT_SPAN, 0, 0, 0, 0), 1,
                mk_wr(KIND_MEM, 16'h1234, 8'h80, 4'h0, 1'b1), '0);
    add_req_row(mk_req(ACT_FLIP, 0, 0, 0, 0), 2,
                mk_wr(KIND_REG, REG_START_LOW, 8'h34, 4'h0, 1'b0),
                mk_wr(KIND_REG, REG_START_HIGH, 8'h12, 4'h0, 1'b1));
    add_req_row(mk_req(ACT_SPAN, 1, 510, 257, 11), PREDICTED, '0, '0);
    add_cfg_row(CFG_ROW_BYTES, 16'd1);
    add_req_row(mk_req(ACT_SPAN, 63, 64, 511, 8), PREDICTED, '0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    prev_req = 1'b0;
    foreach (dir_steps[i]) begin
      st = dir_steps[i];
      if (st.is_cfg) begin
        if (prev_req) wait_idle();
        write_register(st.idx, st.val);
        prev_req = 1'b0;
      end else begin
        send_request(st.req, st.n_typed, st.e0, st.e1);
        prev_req = 1'b1;
      end
    end

    // Random phases, each with fresh register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       v = 16'd0;
        1:       v = 16'd1;
        2:       v = 16'd64;
        3:       v = 16'd127;
        default: v = 16'($urandom_range(1, 64));
      endcase
      if ($urandom_range(0, 3) == 0) v[15:RB_W] = 9'($urandom());
      write_register(CFG_ROW_BYTES, v);
      v = 16'($urandom());
      if ($urandom_range(0, 1) == 0) v[15:1] = '0;
      v[0] = ($urandom_range(0, 4) != 0);
      write_register(CFG_DOUBLE_BUFFER, v);
      write_register(CFG_PAGE_ZERO_BASE, pick_base());
      write_register(CFG_PAGE_ONE_BASE, pick_base());
      if (ph == 3) write_register(CFG_IDX_W'($urandom_range(4, 255)), 16'($urandom()));

      // one phase runs flat out; another opens with a long receiver hold-off
      send_idle_pct = (ph == 1) ? 0 : IDLE_PCT;
      take_idle_pct = (ph == 1) ? 0 : IDLE_PCT;
      if (ph == 2) hold_asks++;

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        r.act = ($urandom_range(0, 99) < 12) ? ACT_FLIP : ACT_SPAN;
        r.x1 = X_W'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
          0, 1:    r.x2 = X_W'($urandom_range(0, 511));
          2:       r.x2 = (r.x1 < 256) ? 9'd511 : 9'd0;
          default: begin
            w = $urandom_range(0, 40);
            r.x2 = (r.x1 + w > 511) ? 9'd511 : X_W'(r.x1 + w);
          end
        endcase
        if ($urandom_range(0, 1) == 1) begin
          w = r.x1;
          r.x1 = r.x2;
          r.x2 = X_W'(w);
        end
        r.rw = ROW_W'($urandom_range(0, 511));
        r.col = COLOUR_W'($urandom_range(0, 15));
        send_request(r, PREDICTED, '0, '0);
      end
    end

    wait_idle();
    $display("ran %0d requests (%0d flips) over %0d register writes and %0d phases,",
             requests_sent, flips_sent, reg_writes, PHASES);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psf_pkg.sv
rtl/psf_ctrl.sv
rtl/psf_dp.sv
rtl/planar_span_fill_with_page_flip_top.sv
bench/planar_span_fill_with_page_flip_top_test.sv
